// ===== rtl/rrps_pkg.sv =====
package rrps_pkg;

    localparam int TICK_W  = 21;
    localparam int TIME_W  = 16;
    localparam logic [TICK_W-1:0] TICK_MAX = 21'h1FFFFF;
    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_SCHED = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_time;
    } rrps_req_t;

    typedef struct packed {
        logic [3:0]        proc_id;
        logic              is_idle;
        logic [TICK_W-1:0] block_start;
        logic [TICK_W-1:0] block_end;
        logic              finished;
        logic [TICK_W-1:0] turnaround;
        logic [TICK_W-1:0] waiting;
        logic [TICK_W-1:0] response;
        logic              all_done;
    } rrps_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADMIT,
        S_DECIDE,
        S_IMIN,
        S_ICHK,
        S_POP,
        S_SMIN,
        S_SCHK,
        S_SADMIT,
        S_FIN
    } rrps_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADMIT_T0,
        OP_ADMIT_MIN,
        OP_MIN,
        OP_POP,
        OP_IDLE_EMIT,
        OP_SLICE_CHK,
        OP_FIN
    } rrps_op_t;

    typedef struct packed {
        rrps_op_t op;
    } rrps_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic all_done;
        logic ring_empty;
        logic more;
    } rrps_status_t;

endpackage

// ===== rtl/round_robin_process_scheduler_unit.sv =====
// Round-robin process scheduler with a time quantum.
// Request channel: start/busy. A request transfers at a rising edge with start
// high and busy low. req_type 0 loads one process (taken in that same edge,
// busy stays low); loads beyond MAX_PROCS are dropped. req_type 1 schedules
// one Gantt block.
// Result channel: result_valid strobes for one cycle with the block in result;
// the receiver cannot stall, so each result must be taken when shown.
// Steps of a schedule request: an admit sweep over the loaded entries, then a
// decision step. An idle block then takes a min-arrival sweep and an emit step.
// A process slice takes a pop step, a min-arrival sweep and a check step, then
// one admit sweep, min sweep and check per distinct arrival tick inside the
// slice, then a finish step.
// The strobe comes in the first cycle with busy low; the register-file sweeps
// go one entry per cycle. A request that yields no block returns busy low with
// no strobe. time_quantum is written by quantum_we/quantum_data; the user must
// write it only while idle, as the block does not enforce this; 0 acts as 1.
// Reset (rst_n low, async) empties the process table and the ready queue,
// zeroes the tick, and sets the quantum to 4.
module round_robin_process_scheduler_unit
    import rrps_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rrps_req_t         request,
    input  logic              quantum_we,
    input  logic [TIME_W-1:0] quantum_data,
    output logic              result_valid,
    output rrps_res_t         result
);

    rrps_cmd_t    cmd;
    rrps_status_t status;

    rrps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    rrps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .quantum_we   (quantum_we),
        .quantum_data (quantum_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !request.req_type) |=> !busy)
        else $error("load transfer made the block busy");

    a_idle_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_idle) |-> (result.block_end > result.block_start))
        else $error("idle block does not move time forward");

    a_no_result_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type) |=> (busy && !result_valid))
        else $error("schedule transfer did not start a sweep");

endmodule

// ===== rtl/rrps_ctrl.sv =====
module rrps_ctrl
    import rrps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         req_type,
    input  rrps_status_t status,
    output rrps_cmd_t    cmd,
    output logic         busy
);

    rrps_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && req_type == REQ_SCHED)
                begin
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT:
            begin
                if (status.scan_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (status.all_done)
                begin
                    state_next = S_IDLE;
                end
                else if (status.ring_empty)
                begin
                    state_next = S_IMIN;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_IMIN:
            begin
                if (status.scan_end)
                begin
                    state_next = S_ICHK;
                end
            end
            S_ICHK:   state_next = S_IDLE;
            S_POP:    state_next = S_SMIN;
            S_SMIN:
            begin
                if (status.scan_end)
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:   state_next = status.more ? S_SADMIT : S_FIN;
            S_SADMIT:
            begin
                if (status.scan_end)
                begin
                    state_next = S_SMIN;
                end
            end
            S_FIN:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        busy   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start && req_type == REQ_LOAD)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_ADMIT:  cmd.op = OP_ADMIT_T0;
            S_DECIDE: cmd.op = OP_NONE;
            S_IMIN:   cmd.op = OP_MIN;
            S_ICHK:   cmd.op = OP_IDLE_EMIT;
            S_POP:    cmd.op = OP_POP;
            S_SMIN:   cmd.op = OP_MIN;
            S_SCHK:   cmd.op = OP_SLICE_CHK;
            S_SADMIT: cmd.op = OP_ADMIT_MIN;
            S_FIN:    cmd.op = OP_FIN;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/rrps_dp.sv =====
module rrps_dp
    import rrps_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rrps_cmd_t         cmd,
    input  rrps_req_t         request,
    input  logic              quantum_we,
    input  logic [TIME_W-1:0] quantum_data,
    output rrps_status_t      status,
    output logic              result_valid,
    output rrps_res_t         result
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_PROCS);

    logic [TIME_W-1:0] arr_mem   [MAX_PROCS];
    logic [TIME_W-1:0] burst_mem [MAX_PROCS];
    logic [TIME_W-1:0] rem_mem   [MAX_PROCS];
    logic [TICK_W-1:0] fs_mem    [MAX_PROCS];
    logic [IW-1:0]     ring_mem  [MAX_PROCS];

    logic [MAX_PROCS-1:0] started_reg, started_next;
    logic [MAX_PROCS-1:0] queued_reg, queued_next;
    logic [TIME_W-1:0] quantum_reg;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CW-1:0]     loaded_reg, loaded_next;
    logic [CW-1:0]     done_reg, done_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [TIME_W-1:0] min_reg, min_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [TICK_W-1:0] start_reg, start_next;
    logic [TICK_W-1:0] end_reg, end_next;
    logic              res_valid_reg, res_valid_next;
    rrps_res_t         res_reg, res_next;

    logic [IW-1:0]     sidx;
    logic              scan_in;
    logic [TICK_W-1:0] thr;
    logic              admit_op;
    logic              admit_hit;
    logic              push_en;
    logic [IW-1:0]     push_data;
    logic [CW:0]       pos_sum;
    logic [IW-1:0]     push_pos;
    logic [IW-1:0]     pidx;
    logic [TIME_W-1:0] q_eff;
    logic [TIME_W-1:0] rem_p;
    logic [TIME_W-1:0] run;
    logic [TICK_W:0]   end_sum;
    logic [TICK_W-1:0] end_sat;
    logic              fin_now;
    logic [TICK_W-1:0] tat;
    logic [TICK_W-1:0] burst_c;
    logic [TICK_W-1:0] wt;
    logic [TICK_W-1:0] rsp;
    logic [IW+3:0]     cur_ext;
    logic [IW-1:0]     load_idx;
    logic              load_en;

    assign sidx     = idx_reg[IW-1:0];
    assign scan_in  = idx_reg < loaded_reg;
    assign admit_op = cmd.op == OP_ADMIT_T0 || cmd.op == OP_ADMIT_MIN;
    assign thr      = (cmd.op == OP_ADMIT_T0) ? tick_reg : TICK_W'(min_reg);
    assign admit_hit = scan_in && !queued_reg[sidx] && (TICK_W'(arr_mem[sidx]) <= thr);
    assign fin_now  = rem_mem[cur_reg] == '0;

    assign push_en   = ((admit_op && admit_hit) || (cmd.op == OP_FIN && !fin_now))
                       && (count_reg < CAP);
    assign push_data = (cmd.op == OP_FIN) ? cur_reg : sidx;
    assign pos_sum   = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign push_pos  = (pos_sum >= (CW+1)'(MAX_PROCS))
                       ? IW'(pos_sum - (CW+1)'(MAX_PROCS)) : IW'(pos_sum);

    assign pidx    = ring_mem[head_reg];
    assign q_eff   = (quantum_reg == '0) ? TIME_W'(1) : quantum_reg;
    assign rem_p   = rem_mem[pidx];
    assign run     = (rem_p < q_eff) ? rem_p : q_eff;
    assign end_sum = (TICK_W+1)'(tick_reg) + (TICK_W+1)'(run);
    assign end_sat = (end_sum > (TICK_W+1)'(TICK_MAX)) ? TICK_MAX : end_sum[TICK_W-1:0];

    assign tat     = end_reg - TICK_W'(arr_mem[cur_reg]);
    assign burst_c = TICK_W'(burst_mem[cur_reg]);
    assign wt      = (tat > burst_c) ? tat - burst_c : '0;
    assign rsp     = fs_mem[cur_reg] - TICK_W'(arr_mem[cur_reg]);
    assign cur_ext = (IW+4)'(cur_reg);

    assign load_en  = cmd.op == OP_LOAD && loaded_reg < CAP;
    assign load_idx = loaded_reg[IW-1:0];

    always_comb
    begin
        started_next   = started_reg;
        queued_next    = queued_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        loaded_next    = loaded_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        min_next       = min_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        if (push_en)
        begin
            count_next = count_reg + CW'(1);
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                if (load_en)
                begin
                    started_next[load_idx] = 1'b0;
                    queued_next[load_idx]  = 1'b0;
                    loaded_next = loaded_reg + CW'(1);
                end
            end
            OP_ADMIT_T0, OP_ADMIT_MIN:
            begin
                idx_next = scan_in ? idx_reg + CW'(1) : '0;
                if (admit_hit)
                begin
                    queued_next[sidx] = 1'b1;
                end
            end
            OP_MIN:
            begin
                idx_next = scan_in ? idx_reg + CW'(1) : '0;
                if (scan_in && !queued_reg[sidx] && (!found_reg || arr_mem[sidx] < min_reg))
                begin
                    min_next   = arr_mem[sidx];
                    found_next = 1'b1;
                end
            end
            OP_POP:
            begin
                cur_next   = pidx;
                head_next  = (head_reg == IW'(MAX_PROCS - 1)) ? '0 : head_reg + IW'(1);
                count_next = count_reg - CW'(1);
                started_next[pidx] = 1'b1;
                start_next = tick_reg;
                end_next   = end_sat;
                tick_next  = end_sat;
            end
            OP_IDLE_EMIT:
            begin
                found_next = 1'b0;
                if (found_reg)
                begin
                    tick_next            = TICK_W'(min_reg);
                    res_valid_next       = 1'b1;
                    res_next.proc_id     = '0;
                    res_next.is_idle     = 1'b1;
                    res_next.block_start = tick_reg;
                    res_next.block_end   = TICK_W'(min_reg);
                    res_next.finished    = 1'b0;
                    res_next.turnaround  = '0;
                    res_next.waiting     = '0;
                    res_next.response    = '0;
                    res_next.all_done    = 1'b0;
                end
            end
            OP_SLICE_CHK:
            begin
                found_next = 1'b0;
            end
            OP_FIN:
            begin
                res_valid_next       = 1'b1;
                res_next.proc_id     = cur_ext[3:0];
                res_next.is_idle     = 1'b0;
                res_next.block_start = start_reg;
                res_next.block_end   = end_reg;
                res_next.finished    = fin_now;
                if (fin_now)
                begin
                    done_next           = done_reg + CW'(1);
                    res_next.turnaround = tat;
                    res_next.waiting    = wt;
                    res_next.response   = rsp;
                end
                else
                begin
                    res_next.turnaround = '0;
                    res_next.waiting    = '0;
                    res_next.response   = '0;
                end
                res_next.all_done = (fin_now ? done_reg + CW'(1) : done_reg) >= loaded_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= '0;
            queued_reg    <= '0;
            quantum_reg   <= QUANTUM_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            tick_reg      <= '0;
            loaded_reg    <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            queued_reg    <= queued_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            loaded_reg    <= loaded_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            if (quantum_we)
            begin
                quantum_reg <= quantum_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        cur_reg   <= cur_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        res_reg   <= res_next;
        if (load_en)
        begin
            arr_mem[load_idx]   <= request.arrival_time;
            burst_mem[load_idx] <= request.burst_time;
        end
        if (load_en)
        begin
            rem_mem[load_idx] <= request.burst_time;
        end
        else if (cmd.op == OP_POP)
        begin
            rem_mem[pidx] <= rem_p - run;
        end
        if (cmd.op == OP_POP && !started_reg[pidx])
        begin
            fs_mem[pidx] <= tick_reg;
        end
        if (push_en)
        begin
            ring_mem[push_pos] <= push_data;
        end
    end

    assign status.scan_end   = !scan_in;
    assign status.all_done   = done_reg >= loaded_reg;
    assign status.ring_empty = count_reg == '0;
    assign status.more       = found_reg && (TICK_W'(min_reg) <= end_reg);

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
